[src/udp_ipv4_frame_builder_core_assert.svh]
// assertion macros shared by the frame builder rtl
`ifndef UDP_IPV4_FRAME_BUILDER_CORE_ASSERT_SVH
`define UDP_IPV4_FRAME_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UIFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame builder check failed");

// next-cycle implication, checked outside reset
`define UIFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame builder check failed");

`endif

[src/uifb_pkg.sv]
`timescale 1ns / 1ps

package uifb_pkg;

	// payload length limits
	localparam logic [10:0] PAYLOAD_MAX = 11'd1024;

	// header layout
	localparam logic [5:0] HDR_BYTES = 6'd56;
	localparam logic [15:0] IP_LEN_BASE = 16'd42;
	localparam logic [15:0] UDP_LEN_BASE = 16'd22;

	// fixed ipv4 header words: version/ihl, flags (df), ttl and protocol
	localparam logic [15:0] CHK_BASE = 16'hA311;

	// prefix tag, first byte most significant
	localparam logic [71:0] TAG_BYTES = 72'h4F_52_4D_32_50_72_6F_6A_00;

	// register indexes
	localparam logic [2:0] REG_DEST_MAC = 3'd0;
	localparam logic [2:0] REG_SOURCE_MAC = 3'd1;
	localparam logic [2:0] REG_SOURCE_IP = 3'd2;
	localparam logic [2:0] REG_DEST_IP = 3'd3;
	localparam logic [2:0] REG_SOURCE_PORT = 3'd4;
	localparam logic [2:0] REG_DEST_PORT = 3'd5;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [10:0] payload_length;
		logic [31:0] sequence_number;
	} payload_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic last_of_frame;
	} frame_t;

endpackage

[src/udp_ipv4_frame_builder_core.sv]
`timescale 1ns / 1ps

// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+--------------------
// payload   | in        | payload_valid / payload_stall  | uifb_pkg::payload_t
// frame     | out       | frame_valid / frame_stall      | uifb_pkg::frame_t
// apb       | in        | psel/penable/pwrite, pready=1  | 64-bit data bus
//
// a payload byte that continues a packet leaves as one frame byte; a byte that
// starts a packet leaves as 57, one for each header byte and one for itself, all
// through the single frame output register at one byte per cycle while no frame_stall.
// arst_n clears the byte counter, pipeline valids and registers; no sweep.
// the next payload byte is taken while the current one waits in the output
// register; a stalled frame holds both stages.

module udp_ipv4_frame_builder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                payload_valid,
	output logic                payload_stall,
	input  uifb_pkg::payload_t  payload,
	output logic                frame_valid,
	input  logic                frame_stall,
	output uifb_pkg::frame_t    frame,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);

	// configuration registers
	logic [47:0] dest_mac_q;
	logic [47:0] source_mac_q;
	logic [31:0] source_ip_q;
	logic [31:0] dest_ip_q;
	logic [15:0] source_port_q;
	logic [15:0] dest_port_q;
	logic [19:0] cfg_sum_q;

	// packet state and stage one
	logic [10:0] remaining_q;
	logic        valid_s1;
	logic        start_s1;
	logic        last_s1;
	logic [7:0]  byte_s1;
	logic [10:0] plen_s1;
	logic [31:0] seq_s1;
	logic [5:0]  hdr_idx_q;
	logic [15:0] chk_q;

	// output register
	logic                frame_valid_q;
	uifb_pkg::frame_t    frame_q;

	logic        cfg_write;
	logic        accept;
	logic        pkt_start;
	logic [10:0] plen_sat;
	logic [10:0] remaining_next;
	logic        out_adv;
	logic        in_hdr;
	logic        emit;
	logic        s1_done;
	logic [15:0] ip_len;
	logic [15:0] udp_len;
	logic [19:0] sum_full;
	logic [16:0] sum_fold1;
	logic [15:0] sum_fold2;
	logic [7:0]  hdr_byte;

	// apb access
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[5:3])
			uifb_pkg::REG_DEST_MAC:    prdata = {16'd0, dest_mac_q};
			uifb_pkg::REG_SOURCE_MAC:  prdata = {16'd0, source_mac_q};
			uifb_pkg::REG_SOURCE_IP:   prdata = {32'd0, source_ip_q};
			uifb_pkg::REG_DEST_IP:     prdata = {32'd0, dest_ip_q};
			uifb_pkg::REG_SOURCE_PORT: prdata = {48'd0, source_port_q};
			uifb_pkg::REG_DEST_PORT:   prdata = {48'd0, dest_port_q};
			default:                   prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_mac_q <= '0;
			source_mac_q <= '0;
			source_ip_q <= '0;
			dest_ip_q <= '0;
			source_port_q <= '0;
			dest_port_q <= '0;
		end else if (cfg_write) begin
			case (paddr[5:3])
				uifb_pkg::REG_DEST_MAC:    dest_mac_q <= pwdata[47:0];
				uifb_pkg::REG_SOURCE_MAC:  source_mac_q <= pwdata[47:0];
				uifb_pkg::REG_SOURCE_IP:   source_ip_q <= pwdata[31:0];
				uifb_pkg::REG_DEST_IP:     dest_ip_q <= pwdata[31:0];
				uifb_pkg::REG_SOURCE_PORT: source_port_q <= pwdata[15:0];
				uifb_pkg::REG_DEST_PORT:   dest_port_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// checksum part that depends on configuration only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_sum_q <= 20'(uifb_pkg::CHK_BASE);
		end else begin
			cfg_sum_q <= 20'(uifb_pkg::CHK_BASE) + 20'(source_ip_q[31:16])
				+ 20'(source_ip_q[15:0]) + 20'(dest_ip_q[31:16]) + 20'(dest_ip_q[15:0]);
		end
	end

	// handshake and byte counter update
	assign out_adv = !frame_valid_q || !frame_stall;
	assign in_hdr = start_s1 && (hdr_idx_q != uifb_pkg::HDR_BYTES);
	assign emit = valid_s1 && out_adv;
	assign s1_done = emit && !in_hdr;
	assign payload_stall = valid_s1 && !s1_done;
	assign accept = payload_valid && !payload_stall;

	always_comb begin
		if (payload.payload_length == 11'd0) begin
			plen_sat = 11'd1;
		end else if (payload.payload_length > uifb_pkg::PAYLOAD_MAX) begin
			plen_sat = uifb_pkg::PAYLOAD_MAX;
		end else begin
			plen_sat = payload.payload_length;
		end
	end

	assign pkt_start = (remaining_q == 11'd0);
	assign remaining_next = (pkt_start ? plen_sat : remaining_q) - 11'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			valid_s1 <= 1'b0;
			hdr_idx_q <= '0;
		end else begin
			if (accept) begin
				remaining_q <= remaining_next;
				valid_s1 <= 1'b1;
				hdr_idx_q <= '0;
			end else begin
				if (s1_done) begin
					valid_s1 <= 1'b0;
				end
				if (emit && in_hdr) begin
					hdr_idx_q <= hdr_idx_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= pkt_start;
			last_s1 <= (remaining_next == 11'd0);
			byte_s1 <= payload.payload_byte;
			if (pkt_start) begin
				plen_s1 <= plen_sat;
				seq_s1 <= payload.sequence_number;
			end
		end
	end

	// length fields and header checksum, settled long before their bytes go out
	assign ip_len = 16'(plen_s1) + uifb_pkg::IP_LEN_BASE;
	assign udp_len = 16'(plen_s1) + uifb_pkg::UDP_LEN_BASE;
	assign sum_full = cfg_sum_q + 20'(ip_len);
	assign sum_fold1 = 17'(sum_full[15:0]) + 17'(sum_full[19:16]);
	assign sum_fold2 = sum_fold1[15:0] + 16'(sum_fold1[16]);

	always_ff @(posedge clk) begin
		chk_q <= ~sum_fold2;
	end

	// header byte select
	always_comb begin
		case (hdr_idx_q)
			6'd0:  hdr_byte = dest_mac_q[47:40];
			6'd1:  hdr_byte = dest_mac_q[39:32];
			6'd2:  hdr_byte = dest_mac_q[31:24];
			6'd3:  hdr_byte = dest_mac_q[23:16];
			6'd4:  hdr_byte = dest_mac_q[15:8];
			6'd5:  hdr_byte = dest_mac_q[7:0];
			6'd6:  hdr_byte = source_mac_q[47:40];
			6'd7:  hdr_byte = source_mac_q[39:32];
			6'd8:  hdr_byte = source_mac_q[31:24];
			6'd9:  hdr_byte = source_mac_q[23:16];
			6'd10: hdr_byte = source_mac_q[15:8];
			6'd11: hdr_byte = source_mac_q[7:0];
			6'd12: hdr_byte = 8'h08;
			6'd14: hdr_byte = 8'h45;
			6'd16: hdr_byte = ip_len[15:8];
			6'd17: hdr_byte = ip_len[7:0];
			6'd20: hdr_byte = 8'h40;
			6'd22: hdr_byte = 8'h1e;
			6'd23: hdr_byte = 8'h11;
			6'd24: hdr_byte = chk_q[15:8];
			6'd25: hdr_byte = chk_q[7:0];
			6'd26: hdr_byte = source_ip_q[31:24];
			6'd27: hdr_byte = source_ip_q[23:16];
			6'd28: hdr_byte = source_ip_q[15:8];
			6'd29: hdr_byte = source_ip_q[7:0];
			6'd30: hdr_byte = dest_ip_q[31:24];
			6'd31: hdr_byte = dest_ip_q[23:16];
			6'd32: hdr_byte = dest_ip_q[15:8];
			6'd33: hdr_byte = dest_ip_q[7:0];
			6'd34: hdr_byte = source_port_q[15:8];
			6'd35: hdr_byte = source_port_q[7:0];
			6'd36: hdr_byte = dest_port_q[15:8];
			6'd37: hdr_byte = dest_port_q[7:0];
			6'd38: hdr_byte = udp_len[15:8];
			6'd39: hdr_byte = udp_len[7:0];
			6'd42: hdr_byte = uifb_pkg::TAG_BYTES[71:64];
			6'd43: hdr_byte = uifb_pkg::TAG_BYTES[63:56];
			6'd44: hdr_byte = uifb_pkg::TAG_BYTES[55:48];
			6'd45: hdr_byte = uifb_pkg::TAG_BYTES[47:40];
			6'd46: hdr_byte = uifb_pkg::TAG_BYTES[39:32];
			6'd47: hdr_byte = uifb_pkg::TAG_BYTES[31:24];
			6'd48: hdr_byte = uifb_pkg::TAG_BYTES[23:16];
			6'd49: hdr_byte = uifb_pkg::TAG_BYTES[15:8];
			6'd50: hdr_byte = uifb_pkg::TAG_BYTES[7:0];
			6'd52: hdr_byte = seq_s1[31:24];
			6'd53: hdr_byte = seq_s1[23:16];
			6'd54: hdr_byte = seq_s1[15:8];
			6'd55: hdr_byte = seq_s1[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (out_adv) begin
			frame_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (in_hdr) begin
				frame_q.frame_byte <= hdr_byte;
				frame_q.last_of_frame <= 1'b0;
			end else begin
				frame_q.frame_byte <= byte_s1;
				frame_q.last_of_frame <= last_s1;
			end
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame = frame_q;

	// checks
	`include "udp_ipv4_frame_builder_core_assert.svh"

	`UIFB_ASSERT_NOW(a_hdr_blocks_input, clk, arst_n, valid_s1 && in_hdr, payload_stall)
	`UIFB_ASSERT_NEXT(a_start_loads_hdr, clk, arst_n, accept && pkt_start, start_s1 && (hdr_idx_q == 6'd0))
	`UIFB_ASSERT_NOW(a_last_clears_count, clk, arst_n, valid_s1 && last_s1, remaining_q == 11'd0)
	`UIFB_ASSERT_NOW(a_hdr_idx_range, clk, arst_n, valid_s1, hdr_idx_q <= uifb_pkg::HDR_BYTES)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	// pacing of each side: no idling, occasional idling, a random idle drawn on every transfer
	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_LIGHT,
		PACE_HEAVY
	} pace_t;

	// unmapped register slots, writes there must be ignored
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam logic [71:0] PREFIX_TAG = 72'h4F_52_4D_32_50_72_6F_6A_00;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic payload_valid = 1'b0;
	logic payload_stall;
	uifb_pkg::payload_t payload = '0;
	logic frame_valid;
	logic frame_stall;
	uifb_pkg::frame_t frame;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	logic recv_stall = 1'b0;
	logic hold_off = 1'b0;
	assign frame_stall = recv_stall | hold_off;

	// stimulus and expected frame bytes
	uifb_pkg::payload_t payload_pending[$];
	uifb_pkg::frame_t frame_bytes_due[$];

	// predictor state: register copies and bytes left in the open packet
	logic [63:0] reg_shadow [0:5];
	logic [10:0] bytes_left = '0;

	pace_t send_pace = PACE_FULL;
	pace_t recv_pace = PACE_FULL;
	int unsigned send_gap = 0;
	int unsigned recv_wait = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	udp_ipv4_frame_builder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.payload_valid(payload_valid),
		.payload_stall(payload_stall),
		.payload(payload),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame(frame),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned draw_wait(input pace_t pace);
		case (pace)
			PACE_FULL: return 0;
			PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
			default: return $urandom_range(0, 14);
		endcase
	endfunction

	// expected frame bytes for one accepted payload byte
	task automatic encapsulate_byte(input uifb_pkg::payload_t item);
		logic [447:0] hdr;
		logic [10:0] plen;
		logic [15:0] ip_len;
		logic [15:0] udp_len;
		logic [15:0] csum;
		logic [31:0] acc;
		logic [31:0] sip;
		logic [31:0] dip;
		uifb_pkg::frame_t fb;
		if (bytes_left == 11'd0) begin
			plen = item.payload_length;
			if (plen == 11'd0)
				plen = 11'd1;
			if (plen > uifb_pkg::PAYLOAD_MAX)
				plen = uifb_pkg::PAYLOAD_MAX;
			ip_len = 16'd42 + 16'(plen);
			udp_len = 16'd22 + 16'(plen);
			sip = reg_shadow[uifb_pkg::REG_SOURCE_IP][31:0];
			dip = reg_shadow[uifb_pkg::REG_DEST_IP][31:0];
			// ones' complement sum over the ipv4 header words, checksum word as zero
			acc = 32'h4500 + 32'(ip_len) + 32'h4000 + 32'h1e11 + 32'(sip[31:16])
				+ 32'(sip[15:0]) + 32'(dip[31:16]) + 32'(dip[15:0]);
			while (acc[19:16] != 4'd0)
				acc = (acc >> 16) + (acc & 32'hFFFF);
			csum = ~acc[15:0];
			hdr = {reg_shadow[uifb_pkg::REG_DEST_MAC][47:0],
				reg_shadow[uifb_pkg::REG_SOURCE_MAC][47:0], 16'h0800,
				8'h45, 8'h00, ip_len, 16'h0000, 8'h40, 8'h00, 8'h1e, 8'h11, csum, sip, dip,
				reg_shadow[uifb_pkg::REG_SOURCE_PORT][15:0],
				reg_shadow[uifb_pkg::REG_DEST_PORT][15:0], udp_len,
				16'h0000, PREFIX_TAG, 8'h00, item.sequence_number};
			for (int i = 0; i < 56; i++) begin
				fb.frame_byte = hdr[447 - 8 * i -: 8];
				fb.last_of_frame = 1'b0;
				frame_bytes_due.push_back(fb);
			end
			bytes_left = plen;
		end
		bytes_left = bytes_left - 11'd1;
		fb.frame_byte = item.payload_byte;
		fb.last_of_frame = (bytes_left == 11'd0);
		frame_bytes_due.push_back(fb);
	endtask

	// payload driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_valid <= 1'b0;
			payload <= '0;
			send_gap <= 0;
		end else begin
			if (payload_valid && !payload_stall)
				encapsulate_byte(payload);
			if (!payload_valid || !payload_stall) begin
				if (send_gap != 0) begin
					payload_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (payload_pending.size() != 0) begin
					payload <= payload_pending.pop_front();
					payload_valid <= 1'b1;
					send_gap <= draw_wait(send_pace);
				end else begin
					payload_valid <= 1'b0;
				end
			end
		end
	end

	// frame receiver stall, one draw per transfer
	always @(posedge clk or negedge arst_n) begin
		int unsigned w;
		if (!arst_n) begin
			recv_stall <= 1'b0;
			recv_wait <= 0;
		end else if (frame_valid && !frame_stall) begin
			w = draw_wait(recv_pace);
			recv_wait <= w;
			recv_stall <= (w != 0);
		end else if (recv_wait > 1) begin
			recv_wait <= recv_wait - 1;
		end else begin
			recv_wait <= 0;
			recv_stall <= 1'b0;
		end
	end

	// frame monitor
	always @(posedge clk) begin
		uifb_pkg::frame_t want;
		if (arst_n && frame_valid && !frame_stall) begin
			if (frame_bytes_due.size() == 0) begin
				$display("%0t: unexpected frame transfer, expected none, actual byte %02h last %b",
					$time, frame.frame_byte, frame.last_of_frame);
				mismatch_count = mismatch_count + 1;
			end else begin
				want = frame_bytes_due.pop_front();
				if (want.frame_byte !== frame.frame_byte || want.last_of_frame !== frame.last_of_frame)
				begin
					$display("%0t: frame mismatch, expected byte %02h last %b, actual byte %02h last %b",
						$time, want.frame_byte, want.last_of_frame, frame.frame_byte,
						frame.last_of_frame);
					mismatch_count = mismatch_count + 1;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic queue_item(input logic [7:0] b, input logic [10:0] len, input logic [31:0] seq);
		uifb_pkg::payload_t item;
		item.payload_byte = b;
		item.payload_length = len;
		item.sequence_number = seq;
		payload_pending.push_back(item);
	endtask

	// packet start with the given length field, then random fields on the rest
	task automatic queue_packet(input logic [10:0] len, input int unsigned nbytes);
		queue_item(8'($urandom), len, $urandom);
		for (int i = 1; i < nbytes; i++)
			queue_item(8'($urandom), 11'($urandom), $urandom);
	endtask

	task automatic queue_random_packets(input int unsigned n_items);
		int unsigned sent;
		int unsigned nb;
		logic [10:0] len;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0: len = 11'd0;
				1, 2: len = 11'($urandom_range(7, 24));
				default: len = 11'($urandom_range(1, 6));
			endcase
			nb = (len == 11'd0) ? 1 : 32'(len);
			queue_packet(len, nb);
			sent += nb;
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (payload_pending.size() != 0 || payload_valid || frame_bytes_due.size() != 0);
	endtask

	// register write, then read back for mapped registers
	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		logic [63:0] mask;
		case (idx)
			uifb_pkg::REG_DEST_MAC, uifb_pkg::REG_SOURCE_MAC: mask = 64'hFFFF_FFFF_FFFF;
			uifb_pkg::REG_SOURCE_IP, uifb_pkg::REG_DEST_IP: mask = 64'hFFFF_FFFF;
			uifb_pkg::REG_SOURCE_PORT, uifb_pkg::REG_DEST_PORT: mask = 64'hFFFF;
			default: mask = '0;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (mask != 0) begin
			reg_shadow[idx] = val & mask;
			@(posedge clk);
			psel <= 1'b1;
			pwrite <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do
				@(posedge clk);
			while (!pready);
			psel <= 1'b0;
			penable <= 1'b0;
			if ((prdata & mask) !== reg_shadow[idx]) begin
				$display("%0t: register %0d readback mismatch, expected %h, actual %h",
					$time, idx, reg_shadow[idx], prdata);
				mismatch_count = mismatch_count + 1;
			end
		end
	endtask

	task automatic cfg_all(input logic [63:0] val);
		cfg_write(uifb_pkg::REG_DEST_MAC, val);
		cfg_write(uifb_pkg::REG_SOURCE_MAC, val);
		cfg_write(uifb_pkg::REG_SOURCE_IP, val);
		cfg_write(uifb_pkg::REG_DEST_IP, val);
		cfg_write(uifb_pkg::REG_SOURCE_PORT, val);
		cfg_write(uifb_pkg::REG_DEST_PORT, val);
	endtask

	task automatic cfg_random();
		cfg_write(uifb_pkg::REG_DEST_MAC, {$urandom, $urandom});
		cfg_write(uifb_pkg::REG_SOURCE_MAC, {$urandom, $urandom});
		cfg_write(uifb_pkg::REG_SOURCE_IP, {$urandom, $urandom});
		cfg_write(uifb_pkg::REG_DEST_IP, {$urandom, $urandom});
		cfg_write(uifb_pkg::REG_SOURCE_PORT, {$urandom, $urandom});
		cfg_write(uifb_pkg::REG_DEST_PORT, {$urandom, $urandom});
	endtask

	initial begin
		for (int i = 0; i < 6; i++)
			reg_shadow[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// all-zero addresses, zero length, single byte, mid-packet fields ignored
		cfg_all(64'h0);
		queue_item(8'h00, 11'd0, 32'h0000_0000);
		queue_item(8'hFF, 11'd1, 32'hFFFF_FFFF);
		queue_item(8'hFF, 11'd3, 32'h8000_0001);
		queue_item(8'h00, 11'h7FF, 32'hFFFF_FFFF);
		queue_item(8'hA5, 11'd0, 32'h0000_0000);
		wait_drained();

		// unmapped slots, then all-ones addresses; stop partway into a packet
		send_pace = PACE_HEAVY;
		recv_pace = PACE_HEAVY;
		cfg_write(REG_SPARE_LO, '1);
		cfg_write(REG_SPARE_HI, '1);
		cfg_all('1);
		queue_packet(11'd2, 2);
		queue_packet(11'd4, 2);
		wait_drained();

		// new addresses while a packet is open, take effect at the next start
		send_pace = PACE_LIGHT;
		recv_pace = PACE_HEAVY;
		cfg_random();
		queue_item(8'($urandom), 11'($urandom), $urandom);
		queue_item(8'($urandom), 11'($urandom), $urandom);
		queue_random_packets(35);
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		send_pace = PACE_FULL;
		recv_pace = PACE_FULL;
		cfg_random();
		queue_random_packets(35);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_off <= 1'b0;
		wait_drained();

		send_pace = PACE_HEAVY;
		recv_pace = PACE_LIGHT;
		cfg_random();
		queue_random_packets(35);
		wait_drained();

		send_pace = PACE_LIGHT;
		recv_pace = PACE_LIGHT;
		cfg_random();
		queue_random_packets(35);
		wait_drained();

		// oversized length saturates to the maximum in the header, packet left open
		send_pace = PACE_FULL;
		recv_pace = PACE_LIGHT;
		cfg_random();
		queue_packet(11'h7FF, 8);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
